/* rtl/qpg_pkg.sv */
`timescale 1ns / 1ps

package qpg_pkg;

  localparam int CoordW   = 16;
  localparam int DiffW    = CoordW + 1;
  localparam int ProdW    = 2 * DiffW;
  localparam int CompW    = ProdW + 1;
  localparam int MagW     = ProdW;
  localparam int HalfW    = MagW / 2;
  localparam int SqW      = 2 * MagW;
  localparam int EsqW     = 2 * CoordW;
  localparam int EsumW    = EsqW + 2;
  localparam int LenW     = EsumW / 2;
  localparam int AreaW    = SqW / 2;
  localparam int QuoW     = 31;
  localparam int RootNW   = (QuoW + 1) / 2;
  localparam int NrmW     = 16;

  localparam int InDataW  = 12 * CoordW;
  localparam int OutDataW = 104;

  localparam int Lat      = 55;
  localparam int ChrDly   = 34;
  localparam int AreaDly  = 13;
  localparam int FlagDly  = 51;

  typedef logic [2:0][DiffW-1:0] vec_t;

  typedef struct packed {
    logic       degen;
    logic [2:0] neg;
  } nflag_t;

endpackage

/* rtl/qpg_isqrt.sv */
`timescale 1ns / 1ps

module qpg_isqrt #(
  parameter int InW = 34
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [InW-1:0]   rad_i,
  output logic [InW/2-1:0] root_o
);

  localparam int Steps = InW / 2;

  logic [InW-1:0] num_q [Steps-1];
  logic [InW-1:0] res_q [Steps];

  for (genvar j = 0; j < Steps; j++) begin : g_st
    localparam logic [InW-1:0] Bit = {{(InW-1){1'b0}}, 1'b1} << (InW - 2 - 2 * j);
    logic [InW-1:0] n_in;
    logic [InW-1:0] r_in;
    logic [InW:0]   t;
    logic           ge;

    if (j == 0) begin : g_first
      assign n_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = num_q[j-1];
      assign r_in = res_q[j-1];
    end

    assign t  = {1'b0, r_in} + {1'b0, Bit};
    assign ge = {1'b0, n_in} >= t;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        res_q[j] <= ge ? (r_in >> 1) + Bit : r_in >> 1;
      end
    end

    if (j < Steps - 1) begin : g_num
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          num_q[j] <= ge ? n_in - t[InW-1:0] : n_in;
        end
      end
    end
  end

  assign root_o = res_q[Steps-1][InW/2-1:0];

endmodule

/* rtl/qpg_div.sv */
`timescale 1ns / 1ps

module qpg_div #(
  parameter int DenW = 68,
  parameter int QuoW = 31
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [DenW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QuoW-1:0] quo_o
);

  logic [DenW-1:0] rem_q [QuoW-1];
  logic [DenW-1:0] den_q [QuoW-1];
  logic [QuoW-1:0] quo_q [QuoW];

  for (genvar j = 0; j < QuoW; j++) begin : g_st
    logic [DenW:0]   r_in;
    logic [DenW:0]   diff;
    logic [DenW-1:0] d_in;
    logic [QuoW-1:0] q_in;
    logic            ge;

    if (j == 0) begin : g_first
      assign r_in = {1'b0, num_i};
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = {rem_q[j-1], 1'b0};
      assign d_in = den_q[j-1];
      assign q_in = quo_q[j-1];
    end

    assign diff = r_in - {1'b0, d_in};
    assign ge   = r_in >= {1'b0, d_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j] <= {q_in[QuoW-2:0], ge};
      end
    end

    if (j < QuoW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= ge ? diff[DenW-1:0] : r_in[DenW-1:0];
          den_q[j] <= d_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule

/* rtl/quad_panel_geometry.sv */
`timescale 1ns / 1ps

// Computes the area, characteristic length and unit normal of one quadrilateral panel per
// item; a new item is taken in every cycle unless the output stalls, and the depth is
// set by the normal path (a 31-stage restoring divider followed by a 16-stage square root).
// A stall on the output holds the whole pipeline. Collinear corners 1, 2 and 3 give a zero
// normal with the degenerate flag set on tuser.

module quad_panel_geometry import qpg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // corner1_x, corner1_y, corner1_z, ..., corner4_x, corner4_y, corner4_z
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // panel_area, char_length, normal_x, normal_y, normal_z, zero fill
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // degenerate
  output logic                m_axis_tuser_o
);

  logic           adv;
  logic [Lat-1:0] vld_q;

  assign adv             = !vld_q[Lat-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid_i};
    end
  end

  // Corner differences.
  vec_t d21_d, d41_d, d43_d, d23_d, d31_d;
  vec_t d21_q, d41_q, d43_q, d23_q, d31_q;

  always_comb begin
    logic signed [CoordW-1:0] p [4][3];
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) begin
        p[i][j] = s_axis_tdata_i[(i*3+j)*CoordW +: CoordW];
      end
    end
    for (int j = 0; j < 3; j++) begin
      d21_d[j] = DiffW'(p[1][j]) - DiffW'(p[0][j]);
      d41_d[j] = DiffW'(p[3][j]) - DiffW'(p[0][j]);
      d43_d[j] = DiffW'(p[3][j]) - DiffW'(p[2][j]);
      d23_d[j] = DiffW'(p[1][j]) - DiffW'(p[2][j]);
      d31_d[j] = DiffW'(p[2][j]) - DiffW'(p[0][j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d21_q <= d21_d;
      d41_q <= d41_d;
      d43_q <= d43_d;
      d23_q <= d23_d;
      d31_q <= d31_d;
    end
  end

  // Cross-product terms and edge squares. Cross 0 is triangle 1-2-4, cross 1 is
  // triangle 3-4-2 and cross 2 gives the normal.
  logic [2:0][2:0][ProdW-1:0] pa_d, pb_d, pa_q, pb_q;
  logic [3:0][2:0][EsqW-1:0]  esq_d, esq_q;

  always_comb begin
    vec_t                    va [3];
    vec_t                    vb [3];
    vec_t                    ve [4];
    logic signed [DiffW-1:0] ta, tb, te;
    va[0] = d21_q; vb[0] = d41_q;
    va[1] = d43_q; vb[1] = d23_q;
    va[2] = d21_q; vb[2] = d31_q;
    ve[0] = d21_q; ve[1] = d23_q; ve[2] = d43_q; ve[3] = d41_q;
    for (int x = 0; x < 3; x++) begin
      for (int i = 0; i < 3; i++) begin
        ta = va[x][(i+1)%3];
        tb = vb[x][(i+2)%3];
        pa_d[x][i] = ta * tb;
        ta = va[x][(i+2)%3];
        tb = vb[x][(i+1)%3];
        pb_d[x][i] = ta * tb;
      end
    end
    for (int e = 0; e < 4; e++) begin
      for (int j = 0; j < 3; j++) begin
        te = ve[e][j];
        esq_d[e][j] = te * te;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_q  <= pa_d;
      pb_q  <= pb_d;
      esq_q <= esq_d;
    end
  end

  logic [2:0][2:0][CompW-1:0] comp_d, comp_q;
  logic [3:0][EsumW-1:0]      esum_d, esum_q;

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      for (int i = 0; i < 3; i++) begin
        comp_d[x][i] = CompW'($signed(pa_q[x][i])) - CompW'($signed(pb_q[x][i]));
      end
    end
    for (int e = 0; e < 4; e++) begin
      esum_d[e] = EsumW'(esq_q[e][0]) + EsumW'(esq_q[e][1]) + EsumW'(esq_q[e][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      comp_q <= comp_d;
      esum_q <= esum_d;
    end
  end

  // Squares of the cross components, split into half-width partial products.
  logic [2:0][2:0][ProdW-1:0] hh_d, hm_d, ll_d, hh_q, hm_q, ll_q;
  nflag_t                     flag_d;

  always_comb begin
    logic signed [CompW-1:0] cv;
    logic [CompW-1:0]        av;
    logic [HalfW-1:0]        hi, lo;
    for (int x = 0; x < 3; x++) begin
      for (int i = 0; i < 3; i++) begin
        cv = comp_q[x][i];
        av = cv[CompW-1] ? CompW'(-cv) : cv;
        hi = av[MagW-1:HalfW];
        lo = av[HalfW-1:0];
        hh_d[x][i] = hi * hi;
        hm_d[x][i] = hi * lo;
        ll_d[x][i] = lo * lo;
      end
    end
    flag_d.degen = (comp_q[2][0] == '0) && (comp_q[2][1] == '0) && (comp_q[2][2] == '0);
    for (int i = 0; i < 3; i++) begin
      flag_d.neg[i] = comp_q[2][i][CompW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hh_q <= hh_d;
      hm_q <= hm_d;
      ll_q <= ll_d;
    end
  end

  logic [2:0][2:0][SqW-1:0] sq_d, sq_q;

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      for (int i = 0; i < 3; i++) begin
        sq_d[x][i] = (SqW'(hh_q[x][i]) << (2 * HalfW)) + (SqW'(hm_q[x][i]) << (HalfW + 1))
                   + SqW'(ll_q[x][i]);
      end
    end
  end

  logic [2:0][SqW-1:0] ps_q, sq2_q, ssum_q, nsq6_q, nsq7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q <= sq_d;
      for (int x = 0; x < 3; x++) begin
        ps_q[x]   <= sq_q[x][0] + sq_q[x][1];
        sq2_q[x]  <= sq_q[x][2];
        ssum_q[x] <= ps_q[x] + sq2_q[x];
      end
      nsq6_q <= sq_q[2];
      nsq7_q <= nsq6_q;
    end
  end

  // Edge lengths and the characteristic length.
  logic [3:0][LenW-1:0] len;

  for (genvar e = 0; e < 4; e++) begin : g_edge
    qpg_isqrt #(.InW(EsumW)) u_edge_sqrt (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  (esum_q[e]),
      .root_o (len[e])
    );
  end

  logic [LenW-1:0] chr_d;
  logic [LenW-1:0] chr_q [ChrDly];

  always_comb begin
    logic [LenW:0] s1, s2;
    s1 = {1'b0, len[0]} + {1'b0, len[2]};
    s2 = {1'b0, len[1]} + {1'b0, len[3]};
    chr_d = (s1[LenW:1] < s2[LenW:1]) ? s1[LenW:1] : s2[LenW:1];
  end

  // Panel area from the two triangle norms.
  logic [1:0][AreaW-1:0] tri_n;

  for (genvar x = 0; x < 2; x++) begin : g_tri
    qpg_isqrt #(.InW(SqW)) u_tri_sqrt (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  (ssum_q[x]),
      .root_o (tri_n[x])
    );
  end

  logic [AreaW:0]   area_sum;
  logic [AreaW-1:0] area_q [AreaDly];

  assign area_sum = {1'b0, tri_n[0]} + {1'b0, tri_n[1]};

  // Unit normal: root of floor(n^2 * 2^30 / |N|^2), then rounded by halving.
  logic [2:0][RootNW-1:0] nroot;

  for (genvar i = 0; i < 3; i++) begin : g_nrm
    logic [QuoW-1:0] quo;
    logic [SqW-1:0]  num;

    assign num = nsq7_q[i];

    qpg_div #(.DenW(SqW), .QuoW(QuoW)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num),
      .den_i (ssum_q[2]),
      .quo_o (quo)
    );

    qpg_isqrt #(.InW(QuoW + 1)) u_nrm_sqrt (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  ({1'b0, quo}),
      .root_o (nroot[i])
    );
  end

  nflag_t flag_q [FlagDly];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      chr_q[0]  <= chr_d;
      area_q[0] <= area_sum[AreaW:1];
      flag_q[0] <= flag_d;
      for (int k = 1; k < ChrDly; k++) begin
        chr_q[k] <= chr_q[k-1];
      end
      for (int k = 1; k < AreaDly; k++) begin
        area_q[k] <= area_q[k-1];
      end
      for (int k = 1; k < FlagDly; k++) begin
        flag_q[k] <= flag_q[k-1];
      end
    end
  end

  // Output register.
  logic [2:0][NrmW-1:0] nrm_d, nrm_q;
  logic [AreaW-1:0]     area_o_q;
  logic [LenW-1:0]      chr_o_q;
  logic                 degen_q;
  nflag_t               flag_last;

  assign flag_last = flag_q[FlagDly-1];

  always_comb begin
    logic [RootNW:0]   rq;
    logic [NrmW-1:0]   q;
    for (int i = 0; i < 3; i++) begin
      rq = {1'b0, nroot[i]} + {{RootNW{1'b0}}, 1'b1};
      q  = NrmW'(rq[RootNW:1]);
      if (flag_last.degen) begin
        nrm_d[i] = '0;
      end else if (flag_last.neg[i]) begin
        nrm_d[i] = -q;
      end else begin
        nrm_d[i] = q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nrm_q    <= nrm_d;
      area_o_q <= area_q[AreaDly-1];
      chr_o_q  <= chr_q[ChrDly-1];
      degen_q  <= flag_last.degen;
    end
  end

  assign m_axis_tdata_o = {{(OutDataW - AreaW - LenW - 3 * NrmW){1'b0}},
                           nrm_q[2], nrm_q[1], nrm_q[0], chr_o_q, area_o_q};
  assign m_axis_tuser_o = degen_q;

endmodule

/* tb/sv/quad_panel_geometry_tb.sv */
`timescale 1ns / 1ps

module quad_panel_geometry_tb;
  import qpg_pkg::*;

  typedef struct {
    logic [33:0] area;
    logic [16:0] len;
    logic [15:0] nx, ny, nz;
    logic        degen;
  } panel_geom_t;

  localparam int RandItems = 400;
  localparam int TailItems = 40;
  localparam int CycleLimit = 200000;
  localparam logic [255:0] One = 256'd1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_vld = 1'b0;
  logic                s_rdy;
  logic [InDataW-1:0]  s_data = '0;
  logic                m_vld;
  logic                m_rdy = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic                m_user;

  quad_panel_geometry dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_vld),
    .s_axis_tready_o (s_rdy),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_vld),
    .m_axis_tready_i (m_rdy),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [InDataW-1:0] panel_q[$];
  panel_geom_t        geom_q[$];
  int n_sent = 0, n_acc = 0, n_rcv = 0, n_degen = 0, n_bad = 0;
  int send_idle = 0, recv_idle = 0, cycles = 0;
  int pause_at = 200, hold_at = 80;
  bit hold_done = 0;

  function automatic logic [255:0] isqrt(logic [255:0] s);
    logic [255:0] r;
    logic [255:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (One << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic [255:0] edge_len(longint p[3], longint q[3]);
    logic [255:0] s;
    longint d;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      d = q[i] - p[i];
      if (d < 0) d = -d;
      s += 256'(d) * 256'(d);
    end
    return isqrt(s);
  endfunction

  function automatic logic [255:0] cross_sq(longint a[3], longint b[3], output longint c[3]);
    logic [255:0] s;
    longint m;
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    s = '0;
    for (int i = 0; i < 3; i++) begin
      m = c[i] < 0 ? -c[i] : c[i];
      s += 256'(m) * 256'(m);
    end
    return s;
  endfunction

  function automatic logic [16:0] mean_pair(logic [255:0] a, logic [255:0] b);
    logic [255:0] m;
    m = (a + b) >> 1;
    return m > 256'd131071 ? 17'h1ffff : m[16:0];
  endfunction

  function automatic panel_geom_t panel_geometry(logic [InDataW-1:0] d);
    panel_geom_t  g;
    longint       p[4][3];
    longint       a[3], b[3], c[3];
    logic [255:0] s1, s2, sum, rhs, lhs, nm;
    logic [16:0]  m1, m2;
    logic [15:0]  q, cand;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 3; j++)
        p[i][j] = longint'($signed(d[(i*3+j)*16 +: 16]));
    for (int j = 0; j < 3; j++) begin
      a[j] = p[1][j] - p[0][j];
      b[j] = p[3][j] - p[0][j];
    end
    s1 = cross_sq(a, b, c);
    for (int j = 0; j < 3; j++) begin
      a[j] = p[3][j] - p[2][j];
      b[j] = p[1][j] - p[2][j];
    end
    s2 = cross_sq(a, b, c);
    sum = (isqrt(s1) + isqrt(s2)) >> 1;
    g.area = sum > 256'h3_ffff_ffff ? 34'h3_ffff_ffff : sum[33:0];
    m1 = mean_pair(edge_len(p[0], p[1]), edge_len(p[2], p[3]));
    m2 = mean_pair(edge_len(p[1], p[2]), edge_len(p[3], p[0]));
    g.len = m1 < m2 ? m1 : m2;
    for (int j = 0; j < 3; j++) begin
      a[j] = p[1][j] - p[0][j];
      b[j] = p[2][j] - p[0][j];
    end
    s1 = cross_sq(a, b, c);
    g.degen = (s1 == 0);
    g.nx = '0; g.ny = '0; g.nz = '0;
    if (!g.degen) begin
      for (int i = 0; i < 3; i++) begin
        nm = 256'(c[i] < 0 ? -c[i] : c[i]);
        rhs = (nm * nm) << 30;
        q = '0;
        for (int bt = 14; bt >= 0; bt--) begin
          cand = q | (16'd1 << bt);
          if (cand > 16'd16384) continue;
          lhs = (256'(2 * cand) - 1) * (256'(2 * cand) - 1) * s1;
          if (lhs <= rhs) q = cand;
        end
        if (c[i] < 0) q = -q;
        if (i == 0) g.nx = q; else if (i == 1) g.ny = q; else g.nz = q;
      end
    end
    return g;
  endfunction

  function automatic logic [InDataW-1:0] pack_panel(int v[12]);
    logic [InDataW-1:0] d;
    for (int i = 0; i < 12; i++) d[i*16 +: 16] = v[i][15:0];
    return d;
  endfunction

  // Sender: new item only once the previous one is taken.
  always @(negedge clk_i) begin
    if (rst_ni && n_sent == n_acc) begin
      if (send_idle > 0) begin
        send_idle <= send_idle - 1;
        s_vld <= 1'b0;
      end else if (panel_q.size() == 0 || (n_acc == pause_at && geom_q.size() != 0)) begin
        s_vld <= 1'b0;
      end else if (panel_q.size() > TailItems && $urandom_range(0, 6) == 0) begin
        send_idle <= $urandom_range(0, 3);
        s_vld <= 1'b0;
      end else begin
        s_data <= panel_q.pop_front();
        s_vld <= 1'b1;
        n_sent <= n_sent + 1;
      end
    end
  end

  // Receiver: random stall bursts, one long hold, none near the end.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && n_rcv == hold_at) begin
        hold_done <= 1'b1;
        recv_idle <= 300;
        m_rdy <= 1'b0;
      end else if (recv_idle > 0) begin
        recv_idle <= recv_idle - 1;
        m_rdy <= 1'b0;
      end else if (panel_q.size() > TailItems && $urandom_range(0, 6) == 0) begin
        recv_idle <= $urandom_range(0, 3);
        m_rdy <= 1'b0;
      end else begin
        m_rdy <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    panel_geom_t e;
    panel_geom_t r;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
    if (s_vld && s_rdy) begin
      geom_q.push_back(panel_geometry(s_data));
      n_acc <= n_acc + 1;
    end
    if (m_vld && m_rdy) begin
      n_rcv <= n_rcv + 1;
      r.area = m_data[33:0];
      r.len = m_data[50:34];
      r.nx = m_data[66:51];
      r.ny = m_data[82:67];
      r.nz = m_data[98:83];
      r.degen = m_user;
      if (r.degen) n_degen <= n_degen + 1;
      if (geom_q.size() == 0) begin
        n_bad <= n_bad + 1;
        if (n_bad < 10) $display("unexpected item %0d: %h", n_rcv, m_data);
      end else begin
        e = geom_q.pop_front();
        if (e.area !== r.area || e.len !== r.len || e.nx !== r.nx || e.ny !== r.ny
            || e.nz !== r.nz || e.degen !== r.degen || m_data[103:99] !== '0) begin
          n_bad <= n_bad + 1;
          if (n_bad < 10)
            $display("item %0d: exp area %h len %h n %h %h %h dg %b, got %h %h %h %h %h %b",
                     n_rcv, e.area, e.len, e.nx, e.ny, e.nz, e.degen,
                     r.area, r.len, r.nx, r.ny, r.nz, r.degen);
        end
      end
    end
  end

  initial begin
    int v[12];
    int base[3], dir[3], k;
    for (int i = 0; i < 12; i++) v[i] = 0;
    panel_q.push_back(pack_panel(v));
    for (int i = 0; i < 12; i++) v[i] = 32767;
    panel_q.push_back(pack_panel(v));
    for (int i = 0; i < 12; i++) v[i] = -32768;
    panel_q.push_back(pack_panel(v));
    v = '{-32768, -32768, -32768, 32767, -32768, 32767, 32767, 32767, -32768,
          -32768, 32767, 32767};
    panel_q.push_back(pack_panel(v));
    v = '{32767, -32768, 0, -32768, 32767, 0, -32768, -32768, 32767,
          32767, 32767, -32768};
    panel_q.push_back(pack_panel(v));
    v = '{0, 0, 0, 256, 0, 0, 256, 256, 0, 0, 256, 0};
    panel_q.push_back(pack_panel(v));
    v = '{0, 0, 0, 0, 0, 256, 0, 256, 256, 0, 256, 0};
    panel_q.push_back(pack_panel(v));
    v = '{0, 0, 0, 256, 256, 256, 512, 512, 512, 7, -3, 100};
    panel_q.push_back(pack_panel(v));
    v = '{-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767, 100, 0, 0};
    panel_q.push_back(pack_panel(v));
    v = '{1, 2, 3, 1, 2, 3, 500, -400, 9, 5, 5, 5};
    panel_q.push_back(pack_panel(v));
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0, -1, -1, 0};
    panel_q.push_back(pack_panel(v));
    v = '{0, 0, 0, 3, 4, 0, -3, 4, 1, 0, 0, 0};
    panel_q.push_back(pack_panel(v));
    for (int n = 0; n < RandItems; n++) begin
      case ($urandom_range(0, 5))
        0: begin
          // Collinear first three corners.
          for (int j = 0; j < 3; j++) begin
            base[j] = $urandom_range(0, 2000) - 1000;
            dir[j] = $urandom_range(0, 200) - 100;
          end
          k = $urandom_range(0, 20) - 10;
          for (int j = 0; j < 3; j++) begin
            v[j] = base[j];
            v[3 + j] = base[j] + dir[j];
            v[6 + j] = base[j] + k * dir[j];
            v[9 + j] = $urandom_range(0, 65535) - 32768;
          end
        end
        1: for (int i = 0; i < 12; i++) v[i] = $urandom_range(0, 1) ? 32767 : -32768;
        2: for (int i = 0; i < 12; i++) v[i] = $urandom_range(0, 64) - 32;
        default: for (int i = 0; i < 12; i++) v[i] = $urandom_range(0, 65535) - 32768;
      endcase
      panel_q.push_back(pack_panel(v));
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (panel_q.size() == 0 && n_sent == n_acc && geom_q.size() == 0);
    repeat (Lat + 10) @(posedge clk_i);
    $display("Checked %0d panels, %0d with collinear corners, through stalls and a long hold.",
             n_rcv, n_degen);
    if (n_bad == 0 && geom_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("FAIL");
    end
    $finish;
  end

endmodule
